// ===== hw/rtl/vat_pkg.sv =====
// vat_pkg: shared types and constants of the 2d vertex affine transform
`timescale 1ns / 1ps
`default_nettype none

package vat_pkg;

    localparam int COORD_BITS     = 16;
    localparam int COEF_FRAC_BITS = 12;
    localparam int COEF_BITS      = COEF_FRAC_BITS + 6;
    localparam int DIFF_BITS      = COORD_BITS + 1;
    localparam int PROD_BITS      = DIFF_BITS + COEF_BITS;
    localparam int SUM_BITS       = COORD_BITS + COEF_FRAC_BITS + 9;
    localparam int RND_BITS       = SUM_BITS + 1;
    localparam int QUO_BITS       = RND_BITS - COEF_FRAC_BITS;
    localparam int CFG_DATA_BITS  = (COORD_BITS > COEF_BITS) ? COORD_BITS : COEF_BITS;
    localparam int REG_IDX_BITS   = 3;
    localparam int IDX_BITS       = 2;

    // transform modes, code 3 acts as translate
    localparam logic [1:0] MODE_TRANSLATE = 2'd0;
    localparam logic [1:0] MODE_SCALE     = 2'd1;
    localparam logic [1:0] MODE_ROTATE    = 2'd2;

    // configuration register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_MODE     = REG_IDX_BITS'(0);
    localparam logic [REG_IDX_BITS-1:0] REG_ANCHOR_X = REG_IDX_BITS'(1);
    localparam logic [REG_IDX_BITS-1:0] REG_ANCHOR_Y = REG_IDX_BITS'(2);
    localparam logic [REG_IDX_BITS-1:0] REG_COEF_A   = REG_IDX_BITS'(3);
    localparam logic [REG_IDX_BITS-1:0] REG_COEF_B   = REG_IDX_BITS'(4);

    // vertex counts per item, as last index
    localparam logic [IDX_BITS-1:0] LAST_SINGLE = IDX_BITS'(0);
    localparam logic [IDX_BITS-1:0] LAST_PAIR   = IDX_BITS'(1);
    localparam logic [IDX_BITS-1:0] LAST_QUAD   = IDX_BITS'(3);

    localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(64'd1 << COEF_FRAC_BITS);
    localparam logic [RND_BITS-1:0] RND_HALF = RND_BITS'(64'd1 << (COEF_FRAC_BITS - 1));
    localparam logic [QUO_BITS-1:0] Q_MAX_POS = QUO_BITS'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    localparam logic [QUO_BITS-1:0] Q_MAX_NEG = QUO_BITS'(64'd1 << (COORD_BITS - 1));

    typedef struct packed {
        logic                         action;
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
    } item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic                         last;
    } result_t;

    typedef struct packed {
        logic [1:0]                   mode;
        logic signed [COORD_BITS-1:0] anchor_x;
        logic signed [COORD_BITS-1:0] anchor_y;
        logic signed [COEF_BITS-1:0]  coef_a;
        logic signed [COEF_BITS-1:0]  coef_b;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
    } point_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vat_cfg.sv =====
// vat_cfg: configuration register file
`timescale 1ns / 1ps
`default_nettype none

module vat_cfg
    import vat_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [REG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:     cfg_next.mode     = cfg_data[1:0];
                REG_ANCHOR_X: cfg_next.anchor_x = cfg_data[COORD_BITS-1:0];
                REG_ANCHOR_Y: cfg_next.anchor_y = cfg_data[COORD_BITS-1:0];
                REG_COEF_A:   cfg_next.coef_a   = cfg_data[COEF_BITS-1:0];
                REG_COEF_B:   cfg_next.coef_b   = cfg_data[COEF_BITS-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode     <= MODE_TRANSLATE;
            cfg_reg.anchor_x <= '0;
            cfg_reg.anchor_y <= '0;
            cfg_reg.coef_a   <= COEF_ONE;
            cfg_reg.coef_b   <= COEF_ONE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/vat_expand.sv =====
// vat_expand: item register and vertex sequencer, one vertex per cycle
`timescale 1ns / 1ps
`default_nettype none

module vat_expand
    import vat_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire item_t      item,
    input  wire logic [1:0] mode,
    output logic            busy,
    output logic            pt_valid,
    output point_t          pt
);

    item_t                item_reg;
    logic                 full_reg;
    logic                 full_next;
    logic [IDX_BITS-1:0]  idx_reg;
    logic [IDX_BITS-1:0]  idx_next;
    logic [IDX_BITS-1:0]  last_idx_reg;
    logic [IDX_BITS-1:0]  last_idx_next;
    logic                 pt_valid_reg;
    point_t               pt_reg;
    point_t               pt_next;
    logic                 accept;
    logic signed [COORD_BITS-1:0] xl;
    logic signed [COORD_BITS-1:0] xh;
    logic signed [COORD_BITS-1:0] yl;
    logic signed [COORD_BITS-1:0] yh;

    // busy while the held item still has vertices after this cycle
    assign busy     = full_reg && (idx_reg != last_idx_reg);
    assign accept   = start && !busy;
    assign pt_valid = pt_valid_reg;
    assign pt       = pt_reg;

    always_comb
    begin
        if (!item.action)
            last_idx_next = LAST_SINGLE;
        else if (mode == MODE_ROTATE)
            last_idx_next = LAST_QUAD;
        else
            last_idx_next = LAST_PAIR;

        if (accept)
        begin
            full_next = 1'b1;
            idx_next  = '0;
        end
        else if (full_reg && !busy)
        begin
            full_next = 1'b0;
            idx_next  = idx_reg;
        end
        else
        begin
            full_next = full_reg;
            idx_next  = full_reg ? idx_reg + IDX_BITS'(1) : idx_reg;
        end
    end

    always_comb
    begin
        xl = (item_reg.first_x < item_reg.second_x) ? item_reg.first_x : item_reg.second_x;
        xh = (item_reg.first_x < item_reg.second_x) ? item_reg.second_x : item_reg.first_x;
        yl = (item_reg.first_y < item_reg.second_y) ? item_reg.first_y : item_reg.second_y;
        yh = (item_reg.first_y < item_reg.second_y) ? item_reg.second_y : item_reg.first_y;

        pt_next.last = (idx_reg == last_idx_reg);
        if (last_idx_reg == LAST_QUAD)
        begin
            // rotated rectangle walks the min/max corners
            unique case (idx_reg)
                IDX_BITS'(0): begin pt_next.x = xl; pt_next.y = yl; end
                IDX_BITS'(1): begin pt_next.x = xh; pt_next.y = yl; end
                IDX_BITS'(2): begin pt_next.x = xh; pt_next.y = yh; end
                default:      begin pt_next.x = xl; pt_next.y = yh; end
            endcase
        end
        else if (idx_reg == '0)
        begin
            pt_next.x = item_reg.first_x;
            pt_next.y = item_reg.first_y;
        end
        else
        begin
            pt_next.x = item_reg.second_x;
            pt_next.y = item_reg.second_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg     <= 1'b0;
            idx_reg      <= '0;
            last_idx_reg <= LAST_SINGLE;
            pt_valid_reg <= 1'b0;
        end
        else
        begin
            full_reg     <= full_next;
            idx_reg      <= idx_next;
            pt_valid_reg <= full_reg;
            if (accept)
                last_idx_reg <= last_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        pt_reg <= pt_next;
    end

`ifndef SYNTHESIS
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> full_reg && idx_reg == '0)
        else $error("accepted item not loaded at vertex zero");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg && !busy && !start |=> !full_reg && !busy)
        else $error("item register not freed after its last vertex");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/vat_datapath.sv =====
// vat_datapath: offset, multiply, sum, round and saturate pipeline
`timescale 1ns / 1ps
`default_nettype none

module vat_datapath
    import vat_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   pt_valid,
    input  wire point_t pt,
    output logic        result_valid,
    output result_t     result
);

    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic                         translate;

    // stage a: offsets from the anchor, or the point itself when translating
    logic                        valid_a_reg;
    logic                        last_a_reg;
    logic signed [DIFF_BITS-1:0] dx_reg;
    logic signed [DIFF_BITS-1:0] dy_reg;
    logic signed [DIFF_BITS-1:0] dx_next;
    logic signed [DIFF_BITS-1:0] dy_next;

    // stage b: products
    logic                        valid_b_reg;
    logic                        last_b_reg;
    logic signed [COEF_BITS-1:0] k0;
    logic signed [COEF_BITS-1:0] k1;
    logic signed [COEF_BITS-1:0] k2;
    logic signed [COEF_BITS-1:0] k3;
    logic signed [PROD_BITS-1:0] m0_reg;
    logic signed [PROD_BITS-1:0] m1_reg;
    logic signed [PROD_BITS-1:0] m2_reg;
    logic signed [PROD_BITS-1:0] m3_reg;

    // stage c: exact sums
    logic                       valid_c_reg;
    logic                       last_c_reg;
    logic signed [SUM_BITS-1:0] sum_x_reg;
    logic signed [SUM_BITS-1:0] sum_y_reg;
    logic signed [SUM_BITS-1:0] sum_x_next;
    logic signed [SUM_BITS-1:0] sum_y_next;

    // stage d: sign and rounded magnitude
    logic                valid_d_reg;
    logic                last_d_reg;
    logic                neg_x_reg;
    logic                neg_y_reg;
    logic [RND_BITS-1:0] mag_x_reg;
    logic [RND_BITS-1:0] mag_y_reg;
    logic [RND_BITS-1:0] mag_x_next;
    logic [RND_BITS-1:0] mag_y_next;

    // stage e: result register
    logic    valid_e_reg;
    result_t res_reg;
    result_t res_next;

    function automatic logic [COORD_BITS-1:0] sat_coord(
        input logic                neg,
        input logic [QUO_BITS-1:0] q
    );
        logic [COORD_BITS-1:0] r;
        if (!neg)
            r = (q > Q_MAX_POS) ? COORD_BITS'(Q_MAX_POS) : q[COORD_BITS-1:0];
        else
            r = (q > Q_MAX_NEG) ? COORD_BITS'(Q_MAX_NEG)
                                : COORD_BITS'(QUO_BITS'(0) - q);
        return r;
    endfunction

    assign ax        = cfg.anchor_x;
    assign ay        = cfg.anchor_y;
    assign translate = (cfg.mode != MODE_SCALE) && (cfg.mode != MODE_ROTATE);

    always_comb
    begin
        // translate feeds the point itself through a unit coefficient
        dx_next = DIFF_BITS'(pt.x) - (translate ? DIFF_BITS'(0) : DIFF_BITS'(ax));
        dy_next = DIFF_BITS'(pt.y) - (translate ? DIFF_BITS'(0) : DIFF_BITS'(ay));

        if (cfg.mode == MODE_ROTATE)
        begin
            k0 = cfg.coef_a;
            k1 = cfg.coef_b;
            k2 = cfg.coef_b;
            k3 = cfg.coef_a;
        end
        else if (cfg.mode == MODE_SCALE)
        begin
            k0 = cfg.coef_a;
            k1 = '0;
            k2 = '0;
            k3 = cfg.coef_b;
        end
        else
        begin
            k0 = COEF_ONE;
            k1 = '0;
            k2 = '0;
            k3 = COEF_ONE;
        end

        sum_x_next = (SUM_BITS'(ax) <<< COEF_FRAC_BITS) + SUM_BITS'(m0_reg) - SUM_BITS'(m1_reg);
        sum_y_next = (SUM_BITS'(ay) <<< COEF_FRAC_BITS) + SUM_BITS'(m2_reg) + SUM_BITS'(m3_reg);

        // magnitude plus half in one add: ones complement plus sign
        mag_x_next = RND_BITS'(sum_x_reg ^ {SUM_BITS{sum_x_reg[SUM_BITS-1]}})
                   + RND_BITS'(sum_x_reg[SUM_BITS-1]) + RND_HALF;
        mag_y_next = RND_BITS'(sum_y_reg ^ {SUM_BITS{sum_y_reg[SUM_BITS-1]}})
                   + RND_BITS'(sum_y_reg[SUM_BITS-1]) + RND_HALF;

        res_next.out_x = sat_coord(neg_x_reg, mag_x_reg[RND_BITS-1:COEF_FRAC_BITS]);
        res_next.out_y = sat_coord(neg_y_reg, mag_y_reg[RND_BITS-1:COEF_FRAC_BITS]);
        res_next.last  = last_d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            valid_e_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= pt_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
            valid_d_reg <= valid_c_reg;
            valid_e_reg <= valid_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        last_a_reg <= pt.last;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;

        last_b_reg <= last_a_reg;
        m0_reg     <= PROD_BITS'(dx_reg) * PROD_BITS'(k0);
        m1_reg     <= PROD_BITS'(dy_reg) * PROD_BITS'(k1);
        m2_reg     <= PROD_BITS'(dx_reg) * PROD_BITS'(k2);
        m3_reg     <= PROD_BITS'(dy_reg) * PROD_BITS'(k3);

        last_c_reg <= last_b_reg;
        sum_x_reg  <= sum_x_next;
        sum_y_reg  <= sum_y_next;

        last_d_reg <= last_c_reg;
        neg_x_reg  <= sum_x_reg[SUM_BITS-1];
        neg_y_reg  <= sum_y_reg[SUM_BITS-1];
        mag_x_reg  <= mag_x_next;
        mag_y_reg  <= mag_y_next;

        res_reg    <= res_next;
    end

    assign result_valid = valid_e_reg;
    assign result       = res_reg;

`ifndef SYNTHESIS
    a_round_sign: assert property (@(posedge clk) disable iff (!rst_n)
        valid_d_reg && !neg_x_reg |=> !result.out_x[COORD_BITS-1])
        else $error("non-negative x sum gave a negative coordinate");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/vertex_affine_transform_2d.sv =====
// vertex_affine_transform_2d: top level of the 2d vertex affine transform
// a result passes the item register, the point register and datapath stages a to e
// throughput: one vertex per cycle; a single vertex item every cycle, a rectangle
//   holds busy high until its last corner (two corners, or four corners in rotate)
// the vertex sequencer sets the rate; results leave one per cycle with no stall
// reset clears all valid bits and loads mode translate, anchor 0, coefficients 1.0
`timescale 1ns / 1ps
`default_nettype none

module vertex_affine_transform_2d
    import vat_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire item_t                    item,
    output logic                          result_valid,
    output result_t                       result,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [REG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t   cfg;
    logic   pt_valid;
    point_t pt;

    vat_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vat_expand u_expand (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .mode     (cfg.mode),
        .busy     (busy),
        .pt_valid (pt_valid),
        .pt       (pt)
    );

    vat_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .pt_valid     (pt_valid),
        .pt           (pt),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef SYNTHESIS
    // vertices of one item leave back to back
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid)
        else $error("gap inside the results of one item");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && item.action))
        else $error("busy rose without a rectangle item");
`endif

endmodule

`default_nettype wire
